// ----- hw/rtl/tlvleb_pkg.sv -----
// shared types and constants for the tlv / leb128 stream parser
// no dependencies; imported by every module of the block
package tlvleb_pkg;

  // longest length varint, in bytes
  localparam int unsigned MAX_VARINT_BYTES = 5;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned OUT_DATA_W = 2 * BYTE_W + LEN_W;

  // parse phases
  localparam logic [PHASE_W-1:0] PH_TAG = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LEN = 2'd1;
  localparam logic [PHASE_W-1:0] PH_VAL = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HDR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

  // one result word
  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] unit_tag;
    logic [LEN_W-1:0]  value_length;
    logic [BYTE_W-1:0] value_data;
    logic              unit_done;
  } result_t;

endpackage

// ----- hw/rtl/tlv_leb128_stream_parser_unit.sv -----
// top level of the tlv / leb128 stream parser
// depends on tlvleb_pkg, tlvleb_core, tlvleb_out_reg
//
// Usage:
//   Slave side takes one payload byte per word: s_tdata holds the byte and
//   s_tlast marks the last byte of the payload. Master side gives one word
//   per result: m_tuser is the kind (header, value byte, malformed unit),
//   m_tdata packs tag, length and value byte, m_tlast ends a unit.
//   Tag bytes and unfinished varint bytes give no result word unless they
//   end the payload. A taken byte is held in the input register and parsed
//   when the result register has room, which then loads its result word.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   tag/length/value state update is combinational between the two registers.
//   Reset clears both registers' valid flags and returns the parser to
//   expecting a tag. When the receiver stalls, the result word holds, the
//   parser stops, and s_tready drops once the input register is also full.
//   The end of a payload always returns the parser to expecting a tag.
module tlv_leb128_stream_parser_unit
  import tlvleb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // final_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] unit_tag, [39:8] value_length,
                                           // [47:40] value_data
  output logic [KIND_W-1:0]     m_tuser,   // [1:0] result_kind
  output logic                  m_tlast    // unit_done
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_final;
  logic              out_ready;
  logic              step;
  logic              emit;
  result_t           core_result;
  result_t           held;

  // parse the held byte when the result register has room
  assign step     = in_valid && out_ready;
  assign s_tready = !in_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  tlvleb_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .final_byte (in_final),
    .emit       (emit),
    .result     (core_result)
  );

  tlvleb_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (step && emit),
    .load_result (core_result),
    .advance     (out_ready),
    .m_tready    (m_tready),
    .ready       (out_ready),
    .m_tvalid    (m_tvalid),
    .held        (held)
  );

  // master side packing
  assign m_tdata = {held.value_data, held.value_length, held.unit_tag};
  assign m_tuser = held.result_kind;
  assign m_tlast = held.unit_done;

endmodule

// ----- hw/rtl/tlvleb_core.sv -----
// parse state and next-state logic: one payload byte per step
// depends on tlvleb_pkg
module tlvleb_core
  import tlvleb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              final_byte,
  output logic              emit,
  output result_t           result
);

  logic [PHASE_W-1:0] parse_phase, parse_phase_next;
  logic [BYTE_W-1:0]  held_tag, held_tag_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [CNT_W-1:0]   varint_count, varint_count_next;
  logic [LEN_W-1:0]   bytes_remaining, bytes_remaining_next;

  logic [5:0]       shift_amt;
  logic [LEN_W-1:0] septet;
  logic [LEN_W-1:0] accum_or;
  logic [LEN_W-1:0] remain_dec;
  logic             more;

  // varint septet placed at its bit offset
  assign shift_amt  = 6'(varint_count) * 6'd7;
  assign septet     = {{(LEN_W-7){1'b0}}, data_byte[6:0]};
  assign accum_or   = length_accum | ((shift_amt < 6'd32) ? (septet << shift_amt[4:0])
                                                         : '0);
  assign remain_dec = bytes_remaining - 1'b1;
  assign more       = data_byte[7] && (varint_count + 1'b1 < CNT_W'(MAX_VARINT_BYTES));

  // next state and result
  always_comb begin
    parse_phase_next     = parse_phase;
    held_tag_next        = held_tag;
    length_accum_next    = length_accum;
    varint_count_next    = varint_count;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    result.result_kind   = KIND_HDR;
    result.unit_tag      = held_tag;
    result.value_length  = '0;
    result.value_data    = '0;
    result.unit_done     = 1'b0;
    unique case (parse_phase)
      PH_LEN: begin
        length_accum_next = accum_or;
        varint_count_next = varint_count + 1'b1;
        if (final_byte) begin
          parse_phase_next = PH_TAG;
          emit = 1'b1;
          result.unit_done = 1'b1;
          if (accum_or != '0) result.result_kind = KIND_ERR;
        end else if (!more) begin
          emit = 1'b1;
          if (accum_or == '0) begin
            parse_phase_next = PH_TAG;
            result.unit_done = 1'b1;
          end else begin
            parse_phase_next     = PH_VAL;
            bytes_remaining_next = accum_or;
            result.value_length  = accum_or;
          end
        end
      end
      PH_VAL: begin
        emit = 1'b1;
        bytes_remaining_next = remain_dec;
        if (remain_dec == '0) begin
          parse_phase_next   = PH_TAG;
          result.result_kind = KIND_VAL;
          result.value_data  = data_byte;
          result.unit_done   = 1'b1;
        end else if (final_byte) begin
          parse_phase_next     = PH_TAG;
          bytes_remaining_next = '0;
          result.result_kind   = KIND_ERR;
          result.unit_done     = 1'b1;
        end else begin
          result.result_kind = KIND_VAL;
          result.value_data  = data_byte;
        end
      end
      default: begin
        // tag byte, also for the unused phase code
        held_tag_next        = data_byte;
        length_accum_next    = '0;
        varint_count_next    = '0;
        bytes_remaining_next = '0;
        result.unit_tag      = data_byte;
        if (final_byte) begin
          parse_phase_next   = PH_TAG;
          emit               = 1'b1;
          result.result_kind = KIND_ERR;
          result.unit_done   = 1'b1;
        end else begin
          parse_phase_next = PH_LEN;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_TAG;
      held_tag        <= '0;
      length_accum    <= '0;
      varint_count    <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      parse_phase     <= parse_phase_next;
      held_tag        <= held_tag_next;
      length_accum    <= length_accum_next;
      varint_count    <= varint_count_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // varint never runs past its maximum length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_LEN |-> varint_count < CNT_W'(MAX_VARINT_BYTES))
    else $error("varint count past maximum");

  // value phase always has bytes left to take
  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_VAL |-> bytes_remaining != '0)
    else $error("value phase with nothing remaining");

  // an open header announces a nonzero length and moves to the value phase
  a_hdr_open: assert property (@(posedge clk) disable iff (rst)
    step && emit && result.result_kind == KIND_HDR && !result.unit_done
      |=> parse_phase == PH_VAL && bytes_remaining == $past(result.value_length))
    else $error("open header without value phase");

  // an error always closes the unit
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    step && emit && result.result_kind == KIND_ERR |=> parse_phase == PH_TAG)
    else $error("error did not return to tag phase");

endmodule

// ----- hw/rtl/tlvleb_out_reg.sv -----
// result register on the master side of the parser
// depends on tlvleb_pkg
module tlvleb_out_reg
  import tlvleb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  input  result_t load_result,
  input  logic    advance,
  input  logic    m_tready,
  output logic    ready,
  output logic    m_tvalid,
  output result_t held
);

  // space for a new word when empty or being drained this cycle
  assign ready = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= load_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      held <= load_result;
    end
  end

  // a held word stays until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(held))
    else $error("result word dropped while stalled");

  // the register only loads when it has room
  a_room: assert property (@(posedge clk) disable iff (rst)
    advance |-> ready)
    else $error("load without room");

  // a loaded word shows up next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    advance && load_valid |=> m_tvalid && held == $past(load_result))
    else $error("loaded word missing");

endmodule
